// File: rtl/crfb_pkg.sv
package crfb_pkg;

    localparam int FB_WIDTH_DEF  = 128;
    localparam int FB_HEIGHT_DEF = 160;

    localparam int CFG_DATA_W = 8;

    // Register indexes on the configuration channel.
    localparam logic [0:0] REG_ACTIVE_WIDTH  = 1'b0;
    localparam logic [0:0] REG_ACTIVE_HEIGHT = 1'b1;

    localparam logic [CFG_DATA_W-1:0] ACTIVE_WIDTH_RST  = 8'd128;
    localparam logic [CFG_DATA_W-1:0] ACTIVE_HEIGHT_RST = 8'd160;

    localparam logic MODE_FILL = 1'b0;
    localparam logic MODE_READ = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [15:0] x_pos;
        logic [15:0] y_pos;
        logic [15:0] rect_width;
        logic [15:0] rect_height;
        logic [15:0] fill_color;
    } cmd_t;

    typedef struct packed {
        logic [15:0] read_color;
        logic [14:0] pixels_written;
    } res_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_XEDGE,
        ST_YEDGE,
        ST_CHECK,
        ST_ADDR,
        ST_FILL,
        ST_READ,
        ST_RWAIT,
        ST_RESP
    } state_t;

endpackage

// File: rtl/crfb_cmd_if.sv
interface crfb_cmd_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [15:0] x_pos;
    logic [15:0] y_pos;
    logic [15:0] rect_width;
    logic [15:0] rect_height;
    logic [15:0] fill_color;

    modport source (
        output valid, mode, x_pos, y_pos, rect_width, rect_height, fill_color,
        input  ready
    );
    modport sink (
        input  valid, mode, x_pos, y_pos, rect_width, rect_height, fill_color,
        output ready
    );
endinterface

// File: rtl/crfb_res_if.sv
interface crfb_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] read_color;
    logic [14:0] pixels_written;

    modport source (
        output valid, read_color, pixels_written,
        input  ready
    );
    modport sink (
        input  valid, read_color, pixels_written,
        output ready
    );
endinterface

// File: rtl/crfb_cfg_if.sv
interface crfb_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [0:0]                           index;
    logic [crfb_pkg::CFG_DATA_W-1:0]      data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// File: rtl/crfb_alu.sv
module crfb_alu (
    input  logic [15:0] a,
    input  logic [15:0] b,
    input  logic        inc,
    output logic [15:0] sum
);

    // a + b + 1 or a + b - 1, wrapping at 16 bits.
    assign sum = a + b + (inc ? 16'h0001 : 16'hFFFF);

endmodule

// File: rtl/crfb_store.sv
module crfb_store #(
    parameter int DEPTH = crfb_pkg::FB_WIDTH_DEF * crfb_pkg::FB_HEIGHT_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [15:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [15:0]   rdata
);

    logic [15:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/crfb_seq.sv
module crfb_seq #(
    parameter int FB_WIDTH  = crfb_pkg::FB_WIDTH_DEF,
    parameter int FB_HEIGHT = crfb_pkg::FB_HEIGHT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  crfb_pkg::cmd_t                cmd,
    output logic                          res_valid,
    input  logic                          res_ready,
    output crfb_pkg::res_t                res,
    input  logic [$clog2(FB_WIDTH+1)-1:0]  eff_w,
    input  logic [$clog2(FB_HEIGHT+1)-1:0] eff_h,
    output logic [15:0]                   alu_a,
    output logic [15:0]                   alu_b,
    output logic                          alu_inc,
    input  logic [15:0]                   alu_sum,
    output logic                          mem_we,
    output logic [$clog2(FB_WIDTH*FB_HEIGHT)-1:0] mem_addr,
    output logic [15:0]                   mem_wdata,
    input  logic [15:0]                   mem_rdata
);

    localparam int DEPTH = FB_WIDTH * FB_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(FB_WIDTH);
    localparam int RW    = $clog2(FB_HEIGHT);
    localparam int EW    = $clog2(FB_WIDTH + 1);
    localparam int EH    = $clog2(FB_HEIGHT + 1);
    localparam int SW    = 17;

    crfb_pkg::state_t state_reg, state_next;
    crfb_pkg::cmd_t   cmd_reg, cmd_next;
    crfb_pkg::res_t   res_reg, res_next;

    logic [15:0]   xs_reg, xs_next, x2_reg, x2_next;
    logic [15:0]   ys_reg, ys_next, y2_reg, y2_next;
    logic [CW-1:0] col_reg, col_next, c0_reg, c0_next, c1_reg, c1_next;
    logic [RW-1:0] row_reg, row_next, r1_reg, r1_next;
    logic [AW-1:0] addr_reg, addr_next, line_reg, line_next;
    logic [14:0]   count_reg, count_next;

    logic signed [SW-1:0] eff_ws, eff_hs;
    logic [EW-1:0]        w_last;
    logic [EH-1:0]        h_last;
    logic                 xs_in, x2_beyond, ys_in, y2_beyond, hit;
    logic [AW-1:0]        line_step;

    assign eff_ws = $signed({{(SW-EW){1'b0}}, eff_w});
    assign eff_hs = $signed({{(SW-EH){1'b0}}, eff_h});
    assign w_last = eff_w - EW'(1);
    assign h_last = eff_h - EH'(1);

    assign xs_in     = $signed(xs_reg) < eff_ws;
    assign x2_beyond = !($signed(x2_reg) < eff_ws);
    assign ys_in     = $signed(ys_reg) < eff_hs;
    assign y2_beyond = !($signed(y2_reg) < eff_hs);

    // Both edges must straddle the active area; a far edge that wrapped
    // negative counts as off the left or top.
    assign hit = (cmd_reg.mode == crfb_pkg::MODE_READ ||
                  (cmd_reg.rect_width != 16'd0 && cmd_reg.rect_height != 16'd0)) &&
                 eff_w != '0 && eff_h != '0 &&
                 xs_in && !x2_reg[15] && ys_in && !y2_reg[15];

    assign line_step = line_reg + AW'(FB_WIDTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= crfb_pkg::ST_CLEAR;
            addr_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        res_reg   <= res_next;
        xs_reg    <= xs_next;
        x2_reg    <= x2_next;
        ys_reg    <= ys_next;
        y2_reg    <= y2_next;
        col_reg   <= col_next;
        c0_reg    <= c0_next;
        c1_reg    <= c1_next;
        row_reg   <= row_next;
        r1_reg    <= r1_next;
        line_reg  <= line_next;
        count_reg <= count_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        res_next   = res_reg;
        xs_next    = xs_reg;
        x2_next    = x2_reg;
        ys_next    = ys_reg;
        y2_next    = y2_reg;
        col_next   = col_reg;
        c0_next    = c0_reg;
        c1_next    = c1_reg;
        row_next   = row_reg;
        r1_next    = r1_reg;
        addr_next  = addr_reg;
        line_next  = line_reg;
        count_next = count_reg;

        cmd_ready = 1'b0;
        res_valid = 1'b0;
        mem_we    = 1'b0;
        mem_wdata = 16'd0;
        alu_a     = cmd_reg.x_pos;
        alu_b     = cmd_reg.rect_width;
        alu_inc   = cmd_reg.rect_width[15];

        case (state_reg)
            crfb_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                addr_next = addr_reg + AW'(1);
                if (addr_reg == AW'(DEPTH - 1))
                begin
                    state_next = crfb_pkg::ST_IDLE;
                end
            end

            crfb_pkg::ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    cmd_next   = cmd;
                    state_next = crfb_pkg::ST_XEDGE;
                end
            end

            crfb_pkg::ST_XEDGE:
            begin
                // Negative width: near edge is x + w + 1, far edge the anchor.
                if (cmd_reg.mode == crfb_pkg::MODE_READ)
                begin
                    xs_next = cmd_reg.x_pos;
                    x2_next = cmd_reg.x_pos;
                end
                else if (cmd_reg.rect_width[15])
                begin
                    xs_next = alu_sum;
                    x2_next = cmd_reg.x_pos;
                end
                else
                begin
                    xs_next = cmd_reg.x_pos;
                    x2_next = alu_sum;
                end
                state_next = crfb_pkg::ST_YEDGE;
            end

            crfb_pkg::ST_YEDGE:
            begin
                alu_a   = cmd_reg.y_pos;
                alu_b   = cmd_reg.rect_height;
                alu_inc = cmd_reg.rect_height[15];
                if (cmd_reg.mode == crfb_pkg::MODE_READ)
                begin
                    ys_next = cmd_reg.y_pos;
                    y2_next = cmd_reg.y_pos;
                end
                else if (cmd_reg.rect_height[15])
                begin
                    ys_next = alu_sum;
                    y2_next = cmd_reg.y_pos;
                end
                else
                begin
                    ys_next = cmd_reg.y_pos;
                    y2_next = alu_sum;
                end
                state_next = crfb_pkg::ST_CHECK;
            end

            crfb_pkg::ST_CHECK:
            begin
                if (!hit)
                begin
                    res_next   = '0;
                    state_next = crfb_pkg::ST_RESP;
                end
                else
                begin
                    c0_next  = xs_reg[15] ? '0 : xs_reg[CW-1:0];
                    col_next = xs_reg[15] ? '0 : xs_reg[CW-1:0];
                    row_next = ys_reg[15] ? '0 : ys_reg[RW-1:0];
                    c1_next  = x2_beyond ? w_last[CW-1:0] : x2_reg[CW-1:0];
                    r1_next  = y2_beyond ? h_last[RW-1:0] : y2_reg[RW-1:0];
                    state_next = crfb_pkg::ST_ADDR;
                end
            end

            crfb_pkg::ST_ADDR:
            begin
                addr_next  = AW'(row_reg) * AW'(FB_WIDTH) + AW'(col_reg);
                line_next  = AW'(row_reg) * AW'(FB_WIDTH) + AW'(col_reg);
                count_next = '0;
                if (cmd_reg.mode == crfb_pkg::MODE_READ)
                begin
                    state_next = crfb_pkg::ST_READ;
                end
                else
                begin
                    state_next = crfb_pkg::ST_FILL;
                end
            end

            crfb_pkg::ST_FILL:
            begin
                mem_we     = 1'b1;
                mem_wdata  = cmd_reg.fill_color;
                count_next = count_reg + 15'd1;
                if (col_reg == c1_reg)
                begin
                    if (row_reg == r1_reg)
                    begin
                        res_next.read_color     = 16'd0;
                        res_next.pixels_written = count_reg + 15'd1;
                        state_next = crfb_pkg::ST_RESP;
                    end
                    else
                    begin
                        row_next  = row_reg + RW'(1);
                        col_next  = c0_reg;
                        line_next = line_step;
                        addr_next = line_step;
                    end
                end
                else
                begin
                    col_next  = col_reg + CW'(1);
                    addr_next = addr_reg + AW'(1);
                end
            end

            crfb_pkg::ST_READ:
            begin
                state_next = crfb_pkg::ST_RWAIT;
            end

            crfb_pkg::ST_RWAIT:
            begin
                res_next.read_color     = mem_rdata;
                res_next.pixels_written = 15'd0;
                state_next = crfb_pkg::ST_RESP;
            end

            crfb_pkg::ST_RESP:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = crfb_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = crfb_pkg::ST_IDLE;
            end
        endcase
    end

    assign mem_addr = addr_reg;
    assign res      = res_reg;

endmodule

// File: rtl/clipped_rect_fill_framebuffer.sv
// Clipped rectangle fill into an RGB565 frame store of FB_WIDTH x FB_HEIGHT
// pixels, row stride FB_WIDTH.
// Channels: cmd takes one command per beat (mode 0 fills a rectangle given
// by a signed anchor, signed width/height and a colour; mode 1 reads the
// pixel at x_pos,y_pos). res returns one beat per command: read_color for a
// read, pixels_written for a fill. cfg writes active_width (index 0) and
// active_height (index 1), always ready; write them only while idle.
// One command is in flight at a time; cmd.ready is low from the accepted
// beat until its result beat has been taken.
// Path from command beat to result valid: a clipped-away fill or a miss
// passes XEDGE, YEDGE and CHECK; a read adds ADDR, READ and RWAIT; a fill
// adds ADDR and then FILL. The pixel loop writes one pixel per cycle
// through the single store write port. Edge arithmetic is done in two
// steps, x edge then y edge, on one shared 16-bit adder.
// After reset the store is cleared one word per cycle, every one of its
// FB_WIDTH*FB_HEIGHT words, with cmd.ready low; cfg writes are taken.
// A stalled receiver holds the result in its output register and the block
// takes no new command until it is accepted.
module clipped_rect_fill_framebuffer #(
    parameter int FB_WIDTH  = crfb_pkg::FB_WIDTH_DEF,
    parameter int FB_HEIGHT = crfb_pkg::FB_HEIGHT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    crfb_cmd_if.sink   cmd,
    crfb_res_if.source res,
    crfb_cfg_if.sink   cfg
);

    localparam int DEPTH = FB_WIDTH * FB_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int EW    = $clog2(FB_WIDTH + 1);
    localparam int EH    = $clog2(FB_HEIGHT + 1);

    logic [crfb_pkg::CFG_DATA_W-1:0] act_w_reg, act_h_reg;
    logic [EW-1:0] eff_w;
    logic [EH-1:0] eff_h;

    crfb_pkg::cmd_t cmd_item;
    crfb_pkg::res_t res_item;

    logic [15:0]   alu_a, alu_b, alu_sum;
    logic          alu_inc;
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [15:0]   mem_wdata, mem_rdata;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_w_reg <= crfb_pkg::ACTIVE_WIDTH_RST;
            act_h_reg <= crfb_pkg::ACTIVE_HEIGHT_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                crfb_pkg::REG_ACTIVE_WIDTH:  act_w_reg <= cfg.data;
                crfb_pkg::REG_ACTIVE_HEIGHT: act_h_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // An active size beyond the store is taken as the store size.
    always_comb
    begin
        if (32'(act_w_reg) > 32'(FB_WIDTH))
            eff_w = EW'(FB_WIDTH);
        else
            eff_w = EW'(act_w_reg);
        if (32'(act_h_reg) > 32'(FB_HEIGHT))
            eff_h = EH'(FB_HEIGHT);
        else
            eff_h = EH'(act_h_reg);
    end

    assign cmd_item.mode        = cmd.mode;
    assign cmd_item.x_pos       = cmd.x_pos;
    assign cmd_item.y_pos       = cmd.y_pos;
    assign cmd_item.rect_width  = cmd.rect_width;
    assign cmd_item.rect_height = cmd.rect_height;
    assign cmd_item.fill_color  = cmd.fill_color;

    assign res.read_color     = res_item.read_color;
    assign res.pixels_written = res_item.pixels_written;

    crfb_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .inc (alu_inc),
        .sum (alu_sum)
    );

    crfb_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_addr),
        .wdata (mem_wdata),
        .raddr (mem_addr),
        .rdata (mem_rdata)
    );

    crfb_seq #(
        .FB_WIDTH  (FB_WIDTH),
        .FB_HEIGHT (FB_HEIGHT)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_ready (cmd.ready),
        .cmd       (cmd_item),
        .res_valid (res.valid),
        .res_ready (res.ready),
        .res       (res_item),
        .eff_w     (eff_w),
        .eff_h     (eff_h),
        .alu_a     (alu_a),
        .alu_b     (alu_b),
        .alu_inc   (alu_inc),
        .alu_sum   (alu_sum),
        .mem_we    (mem_we),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

    // Never ready for a command while a result waits.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.ready && res.valid))
        else $error("command ready while result pending");

    // A result carries either a colour or a pixel count, never both.
    a_one_field: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.pixels_written != 15'd0 |-> res.read_color == 16'd0)
        else $error("fill result with non-zero colour");

    a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid && cmd.ready |=> !cmd.ready)
        else $error("ready again straight after a command beat");

    a_idle_after_res: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.ready |=> cmd.ready && !res.valid)
        else $error("not idle after result beat");

endmodule

// File: test/tb_clipped_rect_fill_framebuffer.sv
module tb_clipped_rect_fill_framebuffer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FBW          = crfb_pkg::FB_WIDTH_DEF;
    localparam int FBH          = crfb_pkg::FB_HEIGHT_DEF;
    localparam int HALF_PERIOD  = 6;
    localparam int IDLE_PERCENT = 14;
    localparam int HOLD_CYCLES  = 400;
    // Slowest legal run: the clearing pass, then about 100 commands each painting the
    // whole store with the longest gaps and stalls, taken more than three times over.
    localparam longint CYCLE_LIMIT = 8_000_000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    crfb_cmd_if cmd_if ();
    crfb_res_if res_if ();
    crfb_cfg_if cfg_if ();

    clipped_rect_fill_framebuffer uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .res   (res_if),
        .cfg   (cfg_if)
    );

    // Shadow copy of the frame store and of the two clipping registers.
    logic [15:0] shadow_frame [FBW*FBH];
    logic [7:0]  shadow_width  = crfb_pkg::ACTIVE_WIDTH_RST;
    logic [7:0]  shadow_height = crfb_pkg::ACTIVE_HEIGHT_RST;

    crfb_pkg::cmd_t pending_cmds [$];
    crfb_pkg::res_t results_due [$];
    crfb_pkg::cmd_t next_cmd;
    crfb_pkg::cmd_t accepted_cmd;
    crfb_pkg::res_t due;
    logic   cmd_fired      = 1'b0;
    logic   hold_off       = 1'b0;
    int     commands_open  = 0;
    int     results_seen   = 0;
    int     error_count    = 0;
    int     fills_done     = 0;
    int     reads_done     = 0;
    int     pixels_painted = 0;
    int     settings_used  = 0;
    longint cycle_count    = 0;

    wire steady = (results_seen >= 70) && (results_seen < 95);

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    function automatic int wrap16(int v);
        return int'(shortint'(v));
    endfunction

    function automatic int clip_width();
        return (int'(shadow_width) > FBW) ? FBW : int'(shadow_width);
    endfunction

    function automatic int clip_height();
        return (int'(shadow_height) > FBH) ? FBH : int'(shadow_height);
    endfunction

    // Paints the clipped rectangle into the shadow store and returns the pixel count.
    function automatic int paint_rect(int x, int y, int w, int h, logic [15:0] colour);
        int aw;
        int ah;
        int x2;
        int y2;
        int row;
        int col;
        int n;
        aw = clip_width();
        ah = clip_height();
        n  = 0;
        if (w == 0 || h == 0)
            return 0;
        // A negative size mirrors the rectangle; -32768 stays negative after negation.
        if (w < 0)
        begin
            x = wrap16(x + w + 1);
            w = wrap16(-w);
        end
        if (x >= aw)
            return 0;
        if (h < 0)
        begin
            y = wrap16(y + h + 1);
            h = wrap16(-h);
        end
        if (y >= ah)
            return 0;
        x2 = wrap16(x + w - 1);
        if (x2 < 0)
            return 0;
        y2 = wrap16(y + h - 1);
        if (y2 < 0)
            return 0;
        if (x < 0)
        begin
            x = 0;
            w = wrap16(x2 + 1);
        end
        if (y < 0)
        begin
            y = 0;
            h = wrap16(y2 + 1);
        end
        if (x2 >= aw)
            w = aw - x;
        if (y2 >= ah)
            h = ah - y;
        for (row = y; row < y + h; row++)
        begin
            for (col = x; col < x + w; col++)
            begin
                if (row >= 0 && row < ah && col >= 0 && col < aw)
                begin
                    shadow_frame[row * FBW + col] = colour;
                    n++;
                end
            end
        end
        return n;
    endfunction

    function automatic crfb_pkg::res_t apply_command(crfb_pkg::cmd_t c);
        crfb_pkg::res_t r;
        int   px;
        int   py;
        int   n;
        r  = '0;
        px = int'($signed(c.x_pos));
        py = int'($signed(c.y_pos));
        if (c.mode == crfb_pkg::MODE_READ)
        begin
            reads_done++;
            if (px >= 0 && px < clip_width() && py >= 0 && py < clip_height())
                r.read_color = shadow_frame[py * FBW + px];
        end
        else
        begin
            fills_done++;
            n = paint_rect(px, py, int'($signed(c.rect_width)), int'($signed(c.rect_height)),
                           c.fill_color);
            pixels_painted += n;
            r.pixels_written = 15'(n);
        end
        return r;
    endfunction

    function automatic crfb_pkg::cmd_t make_cmd(logic mode, int x, int y, int w, int h,
                                                int colour);
        crfb_pkg::cmd_t c;
        c.mode        = mode;
        c.x_pos       = 16'(x);
        c.y_pos       = 16'(y);
        c.rect_width  = 16'(w);
        c.rect_height = 16'(h);
        c.fill_color  = 16'(colour);
        return c;
    endfunction

    // Mostly small rectangles and lines around the visible area, some reads, and a few
    // commands with every field drawn over its full range.
    function automatic crfb_pkg::cmd_t random_cmd();
        crfb_pkg::cmd_t c;
        int   pick;
        pick          = $urandom_range(99);
        c.mode        = crfb_pkg::MODE_FILL;
        c.x_pos       = 16'($urandom_range(155) - 16);
        c.y_pos       = 16'($urandom_range(187) - 16);
        c.rect_width  = 16'($urandom_range(24) - 12);
        c.rect_height = 16'($urandom_range(24) - 12);
        c.fill_color  = 16'($urandom);
        if (pick < 8)
        begin
            c.mode        = ($urandom_range(3) == 0) ? crfb_pkg::MODE_READ : crfb_pkg::MODE_FILL;
            c.x_pos       = 16'($urandom);
            c.y_pos       = 16'($urandom);
            c.rect_width  = 16'($urandom);
            c.rect_height = 16'($urandom);
        end
        else if (pick < 35)
        begin
            c.mode        = crfb_pkg::MODE_READ;
            c.rect_width  = 16'($urandom);
            c.rect_height = 16'($urandom);
        end
        else if (pick < 50)
        begin
            if ($urandom_range(1) == 0)
            begin
                c.rect_width  = ($urandom_range(1) == 0) ? 16'(1) : 16'(-1);
                c.rect_height = 16'($urandom_range(80) - 40);
            end
            else
            begin
                c.rect_height = ($urandom_range(1) == 0) ? 16'(1) : 16'(-1);
                c.rect_width  = 16'($urandom_range(80) - 40);
            end
        end
        return c;
    endfunction

    function automatic void queue_cmd(crfb_pkg::cmd_t c);
        pending_cmds.push_back(c);
        commands_open++;
    endfunction

    task automatic write_reg(input logic [0:0] idx,
                             input logic [crfb_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic set_active(input logic [7:0] w, input logic [7:0] h);
        write_reg(crfb_pkg::REG_ACTIVE_WIDTH, w);
        write_reg(crfb_pkg::REG_ACTIVE_HEIGHT, h);
        settings_used++;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (commands_open != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // Command driver.
    always @(negedge clk)
    begin
        if (!rst_n)
            cmd_if.valid <= 1'b0;
        else if (!cmd_if.valid || cmd_fired)
        begin
            if (pending_cmds.size() != 0 && (steady || $urandom_range(99) >= IDLE_PERCENT))
            begin
                next_cmd = pending_cmds.pop_front();
                cmd_if.valid       <= 1'b1;
                cmd_if.mode        <= next_cmd.mode;
                cmd_if.x_pos       <= next_cmd.x_pos;
                cmd_if.y_pos       <= next_cmd.y_pos;
                cmd_if.rect_width  <= next_cmd.rect_width;
                cmd_if.rect_height <= next_cmd.rect_height;
                cmd_if.fill_color  <= next_cmd.fill_color;
            end
            else
                cmd_if.valid <= 1'b0;
        end
    end

    // Result receiver.
    always @(negedge clk)
    begin
        if (!rst_n)
            res_if.ready <= 1'b0;
        else
            res_if.ready <= !hold_off && (steady || $urandom_range(99) >= IDLE_PERCENT);
    end

    // Once the run is under way the receiver stops for a long while, so that the
    // block holds its result and refuses further commands.
    initial
    begin
        wait (results_seen >= 40);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Monitor: tracks register writes, predicts each accepted command and checks
    // every result beat against the oldest prediction.
    always @(posedge clk)
    begin
        if (!rst_n)
            cmd_fired = 1'b0;
        else
        begin
            cmd_fired = cmd_if.valid && cmd_if.ready;
            if (cfg_if.valid && cfg_if.ready)
            begin
                if (cfg_if.index == crfb_pkg::REG_ACTIVE_WIDTH)
                    shadow_width = cfg_if.data;
                else
                    shadow_height = cfg_if.data;
            end
            if (cmd_fired)
            begin
                accepted_cmd = {cmd_if.mode, cmd_if.x_pos, cmd_if.y_pos, cmd_if.rect_width,
                                cmd_if.rect_height, cmd_if.fill_color};
                results_due.push_back(apply_command(accepted_cmd));
            end
            if (res_if.valid && res_if.ready)
            begin
                results_seen++;
                commands_open--;
                if (results_due.size() == 0)
                begin
                    $display("%0t: unexpected result beat, read_color %h pixels_written %0d",
                             $time, res_if.read_color, res_if.pixels_written);
                    error_count++;
                end
                else
                begin
                    due = results_due.pop_front();
                    if (res_if.read_color !== due.read_color)
                    begin
                        $display("%0t: read_color expected %h, got %h",
                                 $time, due.read_color, res_if.read_color);
                        error_count++;
                    end
                    if (res_if.pixels_written !== due.pixels_written)
                    begin
                        $display("%0t: pixels_written expected %0d, got %0d",
                                 $time, due.pixels_written, res_if.pixels_written);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        cmd_if.valid       = 1'b0;
        cmd_if.mode        = crfb_pkg::MODE_FILL;
        cmd_if.x_pos       = '0;
        cmd_if.y_pos       = '0;
        cmd_if.rect_width  = '0;
        cmd_if.rect_height = '0;
        cmd_if.fill_color  = '0;
        res_if.ready       = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = crfb_pkg::REG_ACTIVE_WIDTH;
        cfg_if.data        = '0;
        foreach (shadow_frame[i])
            shadow_frame[i] = '0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // The block is still clearing its store here, but register writes are taken.
        set_active(8'd128, 8'd160);
        queue_cmd(make_cmd(crfb_pkg::MODE_FILL, 0, 0, 128, 160, 'hFFFF));
        queue_cmd(make_cmd(crfb_pkg::MODE_READ, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(crfb_pkg::MODE_READ, 127, 159, 0, 0, 0));
        queue_cmd(make_cmd(crfb_pkg::MODE_READ, 128, 0, 0, 0, 0));
        queue_cmd(make_cmd(crfb_pkg::MODE_READ, -1, -1, 0, 0, 0));
        queue_cmd(make_cmd(crfb_pkg::MODE_READ, -32768, 32767, -1, -1, 'hFFFF));
        queue_cmd(make_cmd(crfb_pkg::MODE_FILL, 5, 5, 0, 10, 'h1234));
        queue_cmd(make_cmd(crfb_pkg::MODE_FILL, 5, 5, 10, 0, 'h1234));
        queue_cmd(make_cmd(crfb_pkg::MODE_FILL, 10, 10, -5, -3, 'h1234));
        queue_cmd(make_cmd(crfb_pkg::MODE_READ, 6, 8, 0, 0, 0));
        queue_cmd(make_cmd(crfb_pkg::MODE_READ, 11, 10, 0, 0, 0));
        queue_cmd(make_cmd(crfb_pkg::MODE_FILL, 0, 0, -32768, 4, 'h0F0F));
        queue_cmd(make_cmd(crfb_pkg::MODE_FILL, 5, 5, 4, -32768, 'hF0F0));
        // Far edge wraps past +32767, so the rectangle lands off the left.
        queue_cmd(make_cmd(crfb_pkg::MODE_FILL, 100, 0, 32767, 1, 'h4321));
        queue_cmd(make_cmd(crfb_pkg::MODE_FILL, 32767, -32768, 32767, -32768, 'h0000));
        queue_cmd(make_cmd(crfb_pkg::MODE_FILL, -32768, -32768, 32767, 32767, 'h8001));
        queue_cmd(make_cmd(crfb_pkg::MODE_FILL, -3, -3, 6, 6, 'h07E0));
        queue_cmd(make_cmd(crfb_pkg::MODE_FILL, 125, 158, 10, 10, 'h001F));
        queue_cmd(make_cmd(crfb_pkg::MODE_READ, 127, 159, 0, 0, 0));
        queue_cmd(make_cmd(crfb_pkg::MODE_FILL, -32768, 0, -1, 1, 'hAAAA));
        queue_cmd(make_cmd(crfb_pkg::MODE_FILL, 127, 159, -128, -160, 'h5555));
        queue_cmd(make_cmd(crfb_pkg::MODE_READ, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(crfb_pkg::MODE_READ, 32767, -32768, 32767, -32768, 0));
        wait_drained();

        set_active(8'd1, 8'd1);
        queue_cmd(make_cmd(crfb_pkg::MODE_FILL, 0, 0, 1, 1, 'hBEEF));
        queue_cmd(make_cmd(crfb_pkg::MODE_READ, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(crfb_pkg::MODE_READ, 1, 0, 0, 0, 0));
        queue_cmd(make_cmd(crfb_pkg::MODE_READ, 0, 1, 0, 0, 0));
        queue_cmd(make_cmd(crfb_pkg::MODE_FILL, -5, -5, 20, 20, 'h1111));
        queue_cmd(make_cmd(crfb_pkg::MODE_READ, 0, 0, 0, 0, 0));
        wait_drained();

        // Register values above the store size clip at the store edge.
        set_active(8'd255, 8'd255);
        repeat (30) queue_cmd(random_cmd());
        wait_drained();

        // With a zero active area every fill and read misses.
        set_active(8'd0, 8'd0);
        queue_cmd(make_cmd(crfb_pkg::MODE_FILL, 0, 0, 128, 160, 'h2222));
        queue_cmd(make_cmd(crfb_pkg::MODE_READ, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(crfb_pkg::MODE_FILL, -1, -1, 3, 3, 'h3333));
        queue_cmd(make_cmd(crfb_pkg::MODE_READ, 5, 5, 0, 0, 0));
        wait_drained();

        set_active(8'd40, 8'd97);
        repeat (20) queue_cmd(random_cmd());
        wait_drained();

        set_active(8'd128, 8'd160);
        repeat (20) queue_cmd(random_cmd());
        wait_drained();

        if (results_due.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, results_due.size());
            error_count++;
        end
        $display("Checked %0d fills (%0d pixels painted) and %0d reads over %0d clip settings.",
                 fills_done, pixels_painted, reads_done, settings_used);
        $display("Both channels idled at random; results were held off for %0d cycles once.",
                 HOLD_CYCLES);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: sim.f
rtl/crfb_pkg.sv
rtl/crfb_cmd_if.sv
rtl/crfb_res_if.sv
rtl/crfb_cfg_if.sv
rtl/crfb_alu.sv
rtl/crfb_store.sv
rtl/crfb_seq.sv
rtl/clipped_rect_fill_framebuffer.sv
test/tb_clipped_rect_fill_framebuffer.sv
